[hdl/npcs_pkg.sv]
// Shared constants, types and codes for the nearest palette colour search.
package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int INDEX_W         = 8;
   localparam int LIMIT_W         = INDEX_W + 1;
   localparam int COLOUR_W        = 24;
   localparam int CHAN_W          = 8;
   localparam int CHANNELS        = 3;
   localparam int SQ_W            = 2 * CHAN_W;
   localparam int DIST_W          = SQ_W + 2;

   localparam logic [IDX_W-1:0]   LAST_SLOT   = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT = LIMIT_W'(PALETTE_ENTRIES);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // Palette store access from the sequencer.
   typedef struct packed {
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      logic [COLOUR_W-1:0] wr_data;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
   } store_req_type;

   // Tag that follows one palette slot down the compare pipeline.
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

[hdl/npcs_store.sv]
// Palette store: one write port, one registered read port, per-slot valid bits.
module npcs_store (
   input  logic                            clock,
   input  logic                            reset,
   input  npcs_pkg::store_req_type         req,
   output logic [npcs_pkg::COLOUR_W-1:0]   rd_data
);
   import npcs_pkg::*;

   logic [COLOUR_W-1:0]        mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [COLOUR_W-1:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   // Unwritten slots read as black.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= valid_ff[req.rd_addr] ? mem[req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/npcs_dist.sv]
// Shared distance unit: registered channel squares, then their sum.
module npcs_dist (
   input  logic                            clock,
   input  logic [npcs_pkg::COLOUR_W-1:0]   colour,
   input  logic [npcs_pkg::COLOUR_W-1:0]   entry,
   output logic [npcs_pkg::DIST_W-1:0]     distance
);
   import npcs_pkg::*;

   logic [SQ_W-1:0] sq_in [CHANNELS];
   logic [SQ_W-1:0] sq_ff [CHANNELS];

   always_comb begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] diff;
      for (int c = 0; c < CHANNELS; c++) begin
         a        = colour[c*CHAN_W +: CHAN_W];
         b        = entry[c*CHAN_W +: CHAN_W];
         diff     = (a > b) ? (a - b) : (b - a);
         sq_in[c] = SQ_W'(diff) * SQ_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         sq_ff[c] <= sq_in[c];
      end
   end

   assign distance = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);

endmodule

[hdl/npcs_ctrl.sv]
// Sequencer: takes commands, walks the palette, keeps the running best match.
module npcs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            opcode,
   input  logic [npcs_pkg::INDEX_W-1:0]    entry_index,
   input  logic [npcs_pkg::COLOUR_W-1:0]   rgb_colour,
   output npcs_pkg::store_req_type         store_req,
   output logic [npcs_pkg::COLOUR_W-1:0]   query_colour,
   input  logic [npcs_pkg::DIST_W-1:0]     distance,
   output logic                            rsp_strobe,
   output logic [npcs_pkg::INDEX_W-1:0]    rsp_best_index
);
   import npcs_pkg::*;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [COLOUR_W-1:0]  colour_ff;
   tag_type              tag0, tag1_ff, tag2_ff;
   logic [DIST_W-1:0]    best_dist_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic                 take;
   logic [IDX_W-1:0]     new_best_idx;
   logic                 strobe_ff;
   logic [INDEX_W-1:0]   best_out_ff;
   logic                 accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      tag0              = '0;
      store_req         = '0;
      store_req.wr_addr = entry_index[IDX_W-1:0];
      store_req.wr_data = rgb_colour;
      store_req.rd_addr = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && opcode == OP_QUERY) begin
               state_in = ST_SCAN;
            end
            // Drop writes beyond the store.
            store_req.wr_en = accept && (opcode == OP_WRITE) &&
                              ({1'b0, entry_index} < ENTRY_LIMIT);
         end
         ST_SCAN: begin
            store_req.rd_en = 1'b1;
            tag0.vld        = 1'b1;
            tag0.last       = (cnt_ff == LAST_SLOT);
            tag0.idx        = cnt_ff;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tag2_ff.vld && tag2_ff.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && opcode == OP_QUERY) begin
         colour_ff <= rgb_colour;
      end
   end

   // Tags track read data and squares through the store and distance unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
      end
   end

   // Only a strictly smaller distance replaces the best, so ties keep the lower slot.
   assign take         = tag2_ff.vld && ((tag2_ff.idx == '0) || (distance < best_dist_ff));
   assign new_best_idx = take ? tag2_ff.idx : best_idx_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff <= distance;
         best_idx_ff  <= tag2_ff.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag2_ff.vld && tag2_ff.last;
      end
      if (tag2_ff.vld && tag2_ff.last) begin
         best_out_ff <= INDEX_W'(new_best_idx);
      end
   end

   assign query_colour   = colour_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_best_index = best_out_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_tag_while_busy: assert property (@(posedge clock) disable iff (reset)
      (tag1_ff.vld || tag2_ff.vld) |-> busy)
      else $error("compare pipeline active while idle");

   a_strobe_after_last: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(tag2_ff.vld && tag2_ff.last))
      else $error("result issued without final slot compare");

   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !store_req.wr_en)
      else $error("palette written during a search");

endmodule

[hdl/nearest_palette_colour_search.sv]
// Top level of the nearest palette colour search.
//
//   channel   | ports                                          | transfer when
//   ----------+------------------------------------------------+--------------------
//   command   | start, busy, req_opcode, req_entry_index,      | start && !busy
//             | req_rgb_colour                                 |
//   result    | rsp_strobe, rsp_best_index                     | rsp_strobe
//
// A write command leaves busy low.
// A query reads each slot once from the store and passes it through the shared
// distance unit, two pipeline stages deep, before the result is issued.
// The result strobe rises in the cycle busy falls; a new command may transfer then.
// Reset clears the valid bit of every slot at once, so the store reads as black.
// The receiver cannot stall; rsp_strobe marks each result for one cycle.
module nearest_palette_colour_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [npcs_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [npcs_pkg::COLOUR_W-1:0]   req_rgb_colour,
   output logic                            rsp_strobe,
   output logic [npcs_pkg::INDEX_W-1:0]    rsp_best_index
);
   import npcs_pkg::*;

   store_req_type        store_req;
   logic [COLOUR_W-1:0]  entry;
   logic [COLOUR_W-1:0]  query_colour;
   logic [DIST_W-1:0]    distance;

   npcs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .opcode         (req_opcode),
      .entry_index    (req_entry_index),
      .rgb_colour     (req_rgb_colour),
      .store_req      (store_req),
      .query_colour   (query_colour),
      .distance       (distance),
      .rsp_strobe     (rsp_strobe),
      .rsp_best_index (rsp_best_index)
   );

   npcs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (entry)
   );

   npcs_dist u_dist (
      .clock    (clock),
      .colour   (query_colour),
      .entry    (entry),
      .distance (distance)
   );

endmodule
